// ===== src/lcdwwc_pkg.sv =====
// lcdwwc_pkg: shared types and constants of the lcd window write controller
// no dependencies; used by the channel interfaces and every module
package lcdwwc_pkg;

    // register window offsets (bit 0 of the bus offset is dropped before compare)
    localparam logic [11:0] REG_CMD    = 12'h000;
    localparam logic [11:0] REG_DATA   = 12'h004;
    localparam logic [11:0] REG_RDREQ  = 12'h008;
    localparam logic [11:0] REG_SPARE0 = 12'h010;
    localparam logic [11:0] REG_SPARE1 = 12'h014;
    localparam logic [11:0] REG_SPARE2 = 12'h018;
    localparam logic [11:0] REG_STATUS = 12'h01c;

    // command codes
    localparam logic [31:0] CMD_NOP    = 32'h0000_0004;
    localparam logic [31:0] CMD_COLSET = 32'h0000_002a;
    localparam logic [31:0] CMD_ROWSET = 32'h0000_002b;
    localparam logic [31:0] CMD_MEMWR  = 32'h0000_002c;

    // status flags
    localparam logic [31:0] ST_FFEMPTY = 32'h8000_0000;
    localparam logic [31:0] ST_RREADY  = 32'h0000_4000;

    // access kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BAD_CMD = 2'd1;
    localparam logic [1:0] ERR_BAD_REG = 2'd2;
    localparam logic [1:0] ERR_OFF_PNL = 2'd3;

    typedef enum logic [1:0] {
        CC_NONE = 2'd0,
        CC_COL  = 2'd1,
        CC_ROW  = 2'd2,
        CC_MEM  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [31:0] read_data;
        logic        pixel_valid;
        logic [16:0] pixel_index;
        logic [23:0] pixel_color;
        logic [1:0]  error_code;
    } t_result;

endpackage

// ===== src/lcdwwc_req_if.sv =====
// lcdwwc_req_if: valid/ready channel carrying one bus access
// depends on lcdwwc_pkg
interface lcdwwc_req_if import lcdwwc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [11:0] reg_offset;
    logic [31:0] write_data;

    modport source (output valid, output req_type, output reg_offset, output write_data,
                     input ready);
    modport sink   (input valid, input req_type, input reg_offset, input write_data,
                     output ready);
endinterface

// ===== src/lcdwwc_rsp_if.sv =====
// lcdwwc_rsp_if: valid/ready channel carrying one access result
// depends on lcdwwc_pkg
interface lcdwwc_rsp_if import lcdwwc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        pixel_valid;
    logic [16:0] pixel_index;
    logic [23:0] pixel_color;
    logic [1:0]  error_code;

    modport source (output valid, output read_data, output pixel_valid, output pixel_index,
                     output pixel_color, output error_code, input ready);
    modport sink   (input valid, input read_data, input pixel_valid, input pixel_index,
                     input pixel_color, input error_code, output ready);
endinterface

// ===== src/lcd_window_write_controller.sv =====
// lcd_window_write_controller: bus access front end of an lcd register window
// with column/row address set and pixel streaming into framebuffer positions
// depends on lcdwwc_pkg, lcdwwc_req_if, lcdwwc_rsp_if, lcdwwc_engine, lcdwwc_out_stage
//
// usage
//   i_req carries one bus access per transaction (kind, byte offset, data)
//   o_rsp carries exactly one result per access: status read data, an
//   optional pixel write (index, color) and an error code
//   the result of an accepted access is registered and shown on o_rsp in
//   the cycle after acceptance
//   throughput is one access per cycle unless o_rsp stalls; the state update
//   and the result are formed in the cycle of acceptance, the row times width
//   product being the longest path, and a single result register holds the output
//   when o_rsp stalls the result register keeps its transaction and i_req
//   ready drops; the stall reaches the input in the same cycle
//   reset (synchronous, active low) empties the result register, clears the
//   command, window bounds, cursor and status, and marks the window as done
//   offsets 0x10, 0x14 and 0x18 are accepted and have no effect
module lcd_window_write_controller import lcdwwc_pkg::*; #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcdwwc_req_if.sink    i_req,
    lcdwwc_rsp_if.source  o_rsp
);

    t_result w_result;
    logic    w_can_take;
    logic    w_accept;

    assign i_req.ready = w_can_take;
    assign w_accept    = i_req.valid && w_can_take;

    lcdwwc_engine #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_req_type   (i_req.req_type),
        .i_reg_offset (i_req.reg_offset),
        .i_write_data (i_req.write_data),
        .o_result     (w_result)
    );

    lcdwwc_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_result   (w_result),
        .o_can_take (w_can_take),
        .o_rsp      (o_rsp)
    );

endmodule

// ===== src/lcdwwc_engine.sv =====
// lcdwwc_engine: command, window bound and pixel cursor state; computes the
// result of one access from the state. depends on lcdwwc_pkg
module lcdwwc_engine import lcdwwc_pkg::*; #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_req_type,
    input  logic [11:0] i_reg_offset,
    input  logic [31:0] i_write_data,
    output t_result     o_result
);

    localparam logic [15:0] PanelW16 = 16'(PANEL_WIDTH);
    localparam logic [15:0] PanelH16 = 16'(PANEL_HEIGHT);
    localparam logic [16:0] PanelW17 = 17'(PANEL_WIDTH);

    logic        r_st_ffempty, n_st_ffempty;
    logic        r_st_rready,  n_st_rready;
    t_cmd        r_cmd,        n_cmd;
    logic        r_wants,      n_wants;
    logic [2:0]  r_count,      n_count;
    logic [7:0]  r_first,      n_first;
    logic [15:0] r_stg_start,  n_stg_start;
    logic [7:0]  r_high,       n_high;
    logic [15:0] r_col_start,  n_col_start;
    logic [15:0] r_col_end,    n_col_end;
    logic [15:0] r_row_start,  n_row_start;
    logic [15:0] r_row_end,    n_row_end;
    logic [15:0] r_cur_col,    n_cur_col;
    logic [15:0] r_cur_row,    n_cur_row;
    logic        r_done,       n_done;

    logic [11:0] w_reg;
    logic        w_is_read;
    logic        w_off_panel;
    logic [16:0] w_index;

    assign w_reg       = {i_reg_offset[11:1], 1'b0};
    assign w_is_read   = (i_req_type == REQ_READ);
    assign w_off_panel = (r_cur_col >= PanelW16) || (r_cur_row >= PanelH16);
    assign w_index     = 17'(r_cur_row) * PanelW17 + 17'(r_cur_col);

    always_comb begin
        logic [15:0] v_word;
        n_st_ffempty = r_st_ffempty;
        n_st_rready  = r_st_rready;
        n_cmd        = r_cmd;
        n_wants      = r_wants;
        n_count      = r_count;
        n_first      = r_first;
        n_stg_start  = r_stg_start;
        n_high       = r_high;
        n_col_start  = r_col_start;
        n_col_end    = r_col_end;
        n_row_start  = r_row_start;
        n_row_end    = r_row_end;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_done       = r_done;
        o_result     = '0;
        v_word       = 16'h0000;

        unique case (w_reg)
            REG_CMD: begin
                n_st_ffempty = 1'b1;
                n_st_rready  = 1'b0;
                if (!w_is_read) begin
                    n_count = 3'd0;
                    if (i_write_data == CMD_NOP) begin
                        n_cmd   = CC_NONE;
                        n_wants = 1'b0;
                    end else if (i_write_data == CMD_COLSET) begin
                        n_cmd   = CC_COL;
                        n_wants = 1'b1;
                    end else if (i_write_data == CMD_ROWSET) begin
                        n_cmd   = CC_ROW;
                        n_wants = 1'b1;
                    end else if (i_write_data == CMD_MEMWR) begin
                        n_cmd     = CC_MEM;
                        n_cur_col = r_col_start;
                        n_cur_row = r_row_start;
                        n_done    = (r_col_end < r_col_start) || (r_row_end < r_row_start);
                        n_wants   = !n_done;
                    end else begin
                        n_cmd               = CC_NONE;
                        n_wants             = 1'b0;
                        o_result.error_code = ERR_BAD_CMD;
                    end
                end
            end
            REG_DATA: begin
                n_st_ffempty = 1'b1;
                n_st_rready  = 1'b0;
                if (!w_is_read && r_wants) begin
                    if (r_cmd == CC_COL || r_cmd == CC_ROW) begin
                        case (r_count)
                            3'd0: n_first = i_write_data[7:0];
                            3'd1: n_stg_start = {r_first, 8'h00} | i_write_data[15:0];
                            3'd2: n_high = i_write_data[7:0];
                            default: begin
                                // fourth word applies the staged bounds
                                v_word = {r_high, 8'h00} | i_write_data[15:0];
                                if (r_cmd == CC_COL) begin
                                    n_col_start = r_stg_start;
                                    n_col_end   = v_word;
                                end else begin
                                    n_row_start = r_stg_start;
                                    n_row_end   = v_word;
                                end
                                n_wants = 1'b0;
                            end
                        endcase
                        n_count = r_count + 3'd1;
                    end else if (r_cmd == CC_MEM && !r_done) begin
                        if (w_off_panel) begin
                            o_result.error_code = ERR_OFF_PNL;
                        end else begin
                            o_result.pixel_valid = 1'b1;
                            o_result.pixel_index = w_index;
                            o_result.pixel_color = i_write_data[23:0];
                        end
                        // raster advance across the window
                        if (r_cur_col == r_col_end) begin
                            n_cur_col = r_col_start;
                            if (r_cur_row == r_row_end) begin
                                n_done  = 1'b1;
                                n_wants = 1'b0;
                            end else begin
                                n_cur_row = r_cur_row + 16'd1;
                            end
                        end else begin
                            n_cur_col = r_cur_col + 16'd1;
                        end
                    end
                end
            end
            REG_RDREQ: begin
                n_st_ffempty = 1'b0;
                n_st_rready  = 1'b1;
            end
            REG_SPARE0, REG_SPARE1, REG_SPARE2: begin
            end
            REG_STATUS: begin
                if (w_is_read) begin
                    o_result.read_data = (r_st_ffempty ? ST_FFEMPTY : 32'h0)
                                       | (r_st_rready ? ST_RREADY : 32'h0);
                end
            end
            default: begin
                o_result.error_code = ERR_BAD_REG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_ffempty <= 1'b0;
            r_st_rready  <= 1'b0;
            r_cmd        <= CC_NONE;
            r_wants      <= 1'b0;
            r_count      <= 3'd0;
            r_first      <= 8'h00;
            r_stg_start  <= 16'h0000;
            r_high       <= 8'h00;
            r_col_start  <= 16'h0000;
            r_col_end    <= 16'h0000;
            r_row_start  <= 16'h0000;
            r_row_end    <= 16'h0000;
            r_cur_col    <= 16'h0000;
            r_cur_row    <= 16'h0000;
            r_done       <= 1'b1;
        end else if (i_accept) begin
            r_st_ffempty <= n_st_ffempty;
            r_st_rready  <= n_st_rready;
            r_cmd        <= n_cmd;
            r_wants      <= n_wants;
            r_count      <= n_count;
            r_first      <= n_first;
            r_stg_start  <= n_stg_start;
            r_high       <= n_high;
            r_col_start  <= n_col_start;
            r_col_end    <= n_col_end;
            r_row_start  <= n_row_start;
            r_row_end    <= n_row_end;
            r_cur_col    <= n_cur_col;
            r_cur_row    <= n_cur_row;
            r_done       <= n_done;
        end
    end

endmodule

// ===== src/lcdwwc_out_stage.sv =====
// lcdwwc_out_stage: result register between the engine and the result channel
// depends on lcdwwc_pkg and lcdwwc_rsp_if
module lcdwwc_out_stage import lcdwwc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  t_result        i_result,
    output logic           o_can_take,
    lcdwwc_rsp_if.source   o_rsp
);

    logic    r_valid;
    t_result r_data;

    // a new result may enter when the slot is empty or is leaving this cycle
    assign o_can_take = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_take) begin
            r_data <= i_result;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.read_data   = r_data.read_data;
    assign o_rsp.pixel_valid = r_data.pixel_valid;
    assign o_rsp.pixel_index = r_data.pixel_index;
    assign o_rsp.pixel_color = r_data.pixel_color;
    assign o_rsp.error_code  = r_data.error_code;

endmodule
